### rtl/neighbor_ratio_map_defines.svh
// Assertion macros shared by the checker.
`ifndef NEIGHBOR_RATIO_MAP_DEFINES_SVH
`define NEIGHBOR_RATIO_MAP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define NRM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("neighbor_ratio_map check failed");

// Next-cycle implication.
`define NRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("neighbor_ratio_map check failed");

`endif

### rtl/nrm_pkg.sv
package nrm_pkg;

    localparam int DefMaxWidth = 1024;
    localparam int DefFracBits = 8;
    localparam int CfgIdxWidth = 0;
    localparam int CfgIdxHeight = 1;
    localparam logic [15:0] RatioSat = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_CHECK,
        ST_DIVIDE,
        ST_OUTPUT
    } nrm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       take_pixel;
        logic       shift_window;
        logic       load_job;
        logic       start_div;
        logic       step_div;
        logic       load_out;
        logic       advance_pos;
        logic [1:0] job_sel;
    } nrm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [3:0] job_mask;
        logic       div_done;
    } nrm_status_t;

endpackage

### rtl/nrm_datapath.sv
module nrm_datapath
    import nrm_pkg::*;
#(
    parameter int MAX_WIDTH = DefMaxWidth,
    parameter int FRAC_BITS = DefFracBits
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  nrm_cmd_t         cmd,
    output nrm_status_t      status,
    input  logic [7:0]       pixel,
    input  logic [10:0]      width_cfg,
    input  logic [15:0]      height_cfg,
    output logic [9:0]       center_col,
    output logic [15:0]      center_row,
    output logic [8*16-1:0]  ratios,
    output logic             zero_center,
    output logic             frame_last
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int NW = 8 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [7:0] older_mem [MAX_WIDTH];
    logic [7:0] newer_mem [MAX_WIDTH];
    logic [7:0] older_rd_reg, newer_rd_reg, pix_reg;
    logic [7:0] win_reg [9];
    logic [15:0] col_reg, row_reg;

    logic [15:0] w_eff, h_eff, x_eff, y_eff;
    logic lastc, lastr;

    always_comb
    begin
        w_eff = {5'd0, width_cfg};
        if (width_cfg == 11'd0) w_eff = 16'd1;
        if (w_eff > 16'(MAX_WIDTH)) w_eff = 16'(MAX_WIDTH);
        h_eff = (height_cfg == 16'd0) ? 16'd1 : height_cfg;
        x_eff = (col_reg > w_eff - 16'd1) ? w_eff - 16'd1 : col_reg;
        y_eff = (row_reg > h_eff - 16'd1) ? h_eff - 16'd1 : row_reg;
        lastc = (x_eff == w_eff - 16'd1);
        lastr = (y_eff == h_eff - 16'd1);
    end

    logic [AW-1:0] addr;
    assign addr = x_eff[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.take_pixel)
        begin
            older_rd_reg <= older_mem[addr];
            newer_rd_reg <= newer_mem[addr];
            pix_reg <= pixel;
        end
        if (cmd.shift_window)
        begin
            older_mem[addr] <= newer_rd_reg;
            newer_mem[addr] <= pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++) win_reg[i] <= 8'd0;
            col_reg <= 16'd0;
            row_reg <= 16'd0;
        end
        else
        begin
            if (cmd.shift_window)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= older_rd_reg;
                win_reg[5] <= newer_rd_reg;
                win_reg[8] <= pix_reg;
            end
            if (cmd.advance_pos)
            begin
                if (lastc)
                begin
                    col_reg <= 16'd0;
                    row_reg <= lastr ? 16'd0 : y_eff + 16'd1;
                end
                else
                begin
                    col_reg <= x_eff + 16'd1;
                end
            end
        end
    end

    logic [3:0] job_mask;
    assign job_mask = {lastr & lastc, lastr & (x_eff != 16'd0),
                       (y_eff != 16'd0) & lastc,
                       (y_eff != 16'd0) & (x_eff != 16'd0)};

    // Job: centre at window (wr, wc) and image (cr, cc).
    logic [1:0] wr_job, wc_job;
    logic [15:0] cr_job, cc_job;
    always_comb
    begin
        wr_job = cmd.job_sel[1] ? 2'd2 : 2'd1;
        wc_job = cmd.job_sel[0] ? 2'd2 : 2'd1;
        cr_job = cmd.job_sel[1] ? y_eff : y_eff - 16'd1;
        cc_job = cmd.job_sel[0] ? x_eff : x_eff - 16'd1;
    end

    // Eight restoring dividers, one quotient bit per cycle, all in step.
    logic [NW-1:0] quo_reg [8];
    logic [8:0]    rem_reg [8];
    logic [NW-1:0] num_reg [8];
    logic [7:0]    inside_reg;
    logic [7:0]    ctr_reg;
    logic [CW-1:0] cnt_reg;
    logic [15:0]   cr_reg, cc_reg;
    logic          last_reg;

    logic signed [2:0] drow [8];
    logic signed [2:0] dcol [8];
    assign drow = '{-3'sd1, 3'sd0, 3'sd1, 3'sd1, 3'sd1, 3'sd0, -3'sd1, -3'sd1};
    assign dcol = '{3'sd1, 3'sd1, 3'sd1, 3'sd0, -3'sd1, -3'sd1, -3'sd1, 3'sd0};

    logic [7:0] in_next;
    logic [7:0] nb_val [8];
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            logic signed [17:0] nr, nc;
            logic signed [3:0] r, c;
            logic [3:0] idx;
            nr = $signed({2'b00, cr_job}) + 18'(drow[k]);
            nc = $signed({2'b00, cc_job}) + 18'(dcol[k]);
            r = $signed({2'b00, wr_job}) + 4'(drow[k]);
            c = $signed({2'b00, wc_job}) + 4'(dcol[k]);
            in_next[k] = (nr >= 0) && (nr < $signed({2'b00, h_eff})) && (nc >= 0)
                && (nc < $signed({2'b00, w_eff})) && (r >= 0) && (r < 3)
                && (c >= 0) && (c < 3);
            idx = in_next[k] ? 4'(r * 3 + c) : 4'd0;
            nb_val[k] = in_next[k] ? win_reg[idx] : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.start_div)
            cnt_reg <= CW'(NW);
        else if (cmd.step_div && cnt_reg != '0)
            cnt_reg <= cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            ctr_reg <= win_reg[4'(wr_job * 3 + wc_job)];
            cr_reg <= cr_job;
            cc_reg <= cc_job;
            last_reg <= (cr_job == h_eff - 16'd1) && (cc_job == w_eff - 16'd1);
            inside_reg <= in_next;
            for (int k = 0; k < 8; k++)
            begin
                num_reg[k] <= {nb_val[k], FRAC_BITS'(0)};
                rem_reg[k] <= 9'd0;
                quo_reg[k] <= '0;
            end
        end
        else if (cmd.step_div && cnt_reg != '0)
        begin
            for (int k = 0; k < 8; k++)
            begin
                logic [8:0] t;
                t = {rem_reg[k][7:0], num_reg[k][NW-1]};
                num_reg[k] <= num_reg[k] << 1;
                if (t >= {1'b0, ctr_reg})
                begin
                    rem_reg[k] <= t - {1'b0, ctr_reg};
                    quo_reg[k] <= {quo_reg[k][NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= t;
                    quo_reg[k] <= {quo_reg[k][NW-2:0], 1'b0};
                end
            end
        end
    end

    assign status = {job_mask, (cnt_reg == '0)};

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            center_col <= cc_reg[9:0];
            center_row <= cr_reg;
            zero_center <= (ctr_reg == 8'd0);
            frame_last <= last_reg;
            for (int k = 0; k < 8; k++)
            begin
                logic [15:0] v;
                if (!inside_reg[k])
                    v = 16'd0;
                else if (ctr_reg == 8'd0)
                    v = RatioSat;
                else if (quo_reg[k] > NW'(RatioSat))
                    v = RatioSat;
                else
                    v = 16'(quo_reg[k]);
                ratios[(7-k)*16 +: 16] <= v;
            end
        end
    end
endmodule

### rtl/nrm_ctrl.sv
module nrm_ctrl
    import nrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  nrm_status_t status,
    output nrm_cmd_t    cmd
);
    nrm_state_t state_reg, state_next;
    logic [3:0] mask_reg, mask_next;
    logic [1:0] job_reg, job_next;
    logic       ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mask_reg <= 4'd0;
            job_reg <= 2'd0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mask_reg <= mask_next;
            job_reg <= job_next;
            ov_reg <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    always_comb
    begin
        logic [1:0] j;
        state_next = state_reg;
        mask_next = mask_reg;
        job_next = job_reg;
        ov_next = ov_reg;
        cmd = '0;
        cmd.job_sel = job_reg;
        in_ready = 1'b0;
        j = 2'd0;
        if (ov_reg && out_ready) ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_pixel = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift_window = 1'b1;
                mask_next = status.job_mask;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (mask_reg == 4'd0)
                begin
                    cmd.advance_pos = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    for (int i = 3; i >= 0; i--)
                        if (mask_reg[i]) j = 2'(i);
                    job_next = j;
                    cmd.job_sel = j;
                    cmd.start_div = 1'b1;
                    mask_next[j] = 1'b0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.step_div = 1'b1;
                if (status.div_done) state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ST_READ is reserved for a registered store read; unused in this build.
endmodule

### rtl/neighbor_ratio_map.sv
// A pixel with no result passes ST_IDLE, ST_SHIFT and ST_CHECK; each result adds
// ST_DIVIDE (eight bit-serial dividers, one quotient bit per cycle) and ST_OUTPUT.
// A new pixel waits for all results of the last; out_ready can stall ST_OUTPUT.
// Reset: rst_n is asynchronous active low; clears control, window and counters,
// and sets both size registers to 156. Line stores are not cleared.
module neighbor_ratio_map
    import nrm_pkg::*;
#(
    parameter int MAX_WIDTH = DefMaxWidth,
    parameter int FRAC_BITS = DefFracBits
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  center_col,
    output logic [15:0] center_row,
    output logic [15:0] ratio_up_right,
    output logic [15:0] ratio_right,
    output logic [15:0] ratio_down_right,
    output logic [15:0] ratio_down,
    output logic [15:0] ratio_down_left,
    output logic [15:0] ratio_left,
    output logic [15:0] ratio_up_left,
    output logic [15:0] ratio_up,
    output logic        zero_center,
    output logic        frame_last
);
    // Size registers; a write is always taken.
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 11'd156;
            height_reg <= 16'd156;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == 1'(CfgIdxWidth)) width_reg <= cfg_data[10:0];
            else height_reg <= cfg_data;
        end
    end

    nrm_cmd_t    cmd;
    nrm_status_t status;
    logic [8*16-1:0] ratios;

    nrm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
    );

    nrm_datapath #(.MAX_WIDTH(MAX_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status), .pixel(pixel),
        .width_cfg(width_reg), .height_cfg(height_reg), .center_col(center_col),
        .center_row(center_row), .ratios(ratios), .zero_center(zero_center),
        .frame_last(frame_last)
    );

    // The ratios leave in the fixed neighbour order, up-right first.
    assign ratio_up_right   = ratios[127:112];
    assign ratio_right      = ratios[111:96];
    assign ratio_down_right = ratios[95:80];
    assign ratio_down       = ratios[79:64];
    assign ratio_down_left  = ratios[63:48];
    assign ratio_left       = ratios[47:32];
    assign ratio_up_left    = ratios[31:16];
    assign ratio_up         = ratios[15:0];
endmodule

### rtl/nrm_checker.sv
`include "neighbor_ratio_map_defines.svh"
module nrm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic zero_center,
    input logic [15:0] ratio_up
);
    `NRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `NRM_ASSERT_IMP(a_zero_sat, out_valid && zero_center, ratio_up == 16'd0 || ratio_up == 16'hFFFF)
    `NRM_ASSERT_NEXT(a_in_gap, in_valid && in_ready, !in_ready)
endmodule

bind neighbor_ratio_map nrm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .zero_center(zero_center),
    .ratio_up(ratio_up)
);

### tb/sv/neighbor_ratio_map_tb.sv
`timescale 1ns / 1ps

module neighbor_ratio_map_tb;
    import nrm_pkg::*;

    // One expected or observed ratio beat.
    typedef struct {
        logic [9:0]  col;
        logic [15:0] row;
        logic [15:0] ratio [8];
        logic        zero;
        logic        last;
    } ratio_beat_t;

    // Mirrors the ratio map: line stores, window, counters and size registers,
    // and holds the ratio beats that are still owed by the block.
    class ratio_scoreboard;
        logic [7:0]  older_line [1024];
        logic [7:0]  newer_line [1024];
        logic [7:0]  win [9];
        int unsigned col_cnt;
        int unsigned row_cnt;
        int unsigned width_reg;
        int unsigned height_reg;
        ratio_beat_t owed [$];
        int          mismatches;
        int          beats_seen;
        int          pixels_seen;
        int          zero_centres;
        int          frames_done;

        function new();
            foreach (older_line[i])
            begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            col_cnt = 0;
            row_cnt = 0;
            width_reg = 156;
            height_reg = 156;
            mismatches = 0;
            beats_seen = 0;
            pixels_seen = 0;
            zero_centres = 0;
            frames_done = 0;
        endfunction

        function void write_reg(int idx, int unsigned val);
            if (idx == CfgIdxWidth)
                width_reg = val & 11'h7FF;
            else if (idx == CfgIdxHeight)
                height_reg = val & 16'hFFFF;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > 1024)
                return 1024;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function logic [15:0] quotient(int unsigned nb, int unsigned ctr);
            int unsigned q;
            if (ctr == 0)
                return RatioSat;
            q = (nb << 8) / ctr;
            return (q > 65535) ? RatioSat : q[15:0];
        endfunction

        // Queues the beat for the centre held at window row wr, column wc.
        function void owe_centre(int wr, int wc, int cr, int cc, int w, int h);
            int          drow [8];
            int          dcol [8];
            ratio_beat_t b;
            int unsigned ctr;
            int          r;
            int          c;
            drow = '{-1, 0, 1, 1, 1, 0, -1, -1};
            dcol = '{1, 1, 1, 0, -1, -1, -1, 0};
            ctr = win[wr * 3 + wc];
            b.col = cc[9:0];
            b.row = cr[15:0];
            for (int k = 0; k < 8; k++)
            begin
                r = wr + drow[k];
                c = wc + dcol[k];
                b.ratio[k] = '0;
                if (cr + drow[k] >= 0 && cr + drow[k] < h && cc + dcol[k] >= 0 &&
                    cc + dcol[k] < w && r >= 0 && r < 3 && c >= 0 && c < 3)
                    b.ratio[k] = quotient(win[r * 3 + c], ctr);
            end
            b.zero = (ctr == 0);
            b.last = (cr == h - 1 && cc == w - 1);
            owed.push_back(b);
        endfunction

        // Called for every accepted pixel beat.
        function void note_pixel(logic [7:0] px);
            int unsigned w;
            int unsigned h;
            int unsigned x;
            int unsigned y;
            bit          lastc;
            bit          lastr;
            w = eff_width();
            h = eff_height();
            x = (col_cnt > w - 1) ? w - 1 : col_cnt;
            y = (row_cnt > h - 1) ? h - 1 : row_cnt;
            pixels_seen++;
            for (int r = 0; r < 3; r++)
            begin
                win[r * 3] = win[r * 3 + 1];
                win[r * 3 + 1] = win[r * 3 + 2];
            end
            win[2] = older_line[x];
            win[5] = newer_line[x];
            win[8] = px;
            older_line[x] = newer_line[x];
            newer_line[x] = px;
            lastc = (x == w - 1);
            lastr = (y == h - 1);
            if (y >= 1 && x >= 1)
                owe_centre(1, 1, y - 1, x - 1, w, h);
            if (y >= 1 && lastc)
                owe_centre(1, 2, y - 1, x, w, h);
            if (lastr && x >= 1)
                owe_centre(2, 1, y, x - 1, w, h);
            if (lastr && lastc)
                owe_centre(2, 2, y, x, w, h);
            if (lastc)
            begin
                col_cnt = 0;
                row_cnt = lastr ? 0 : y + 1;
                if (lastr)
                    frames_done++;
            end
            else
                col_cnt = x + 1;
        endfunction

        function void flag(string what, int unsigned want, int unsigned got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what,
                         want, got);
        endfunction

        // Called for every accepted ratio beat.
        function void check_result(ratio_beat_t got);
            ratio_beat_t want;
            string       dir_name [8];
            dir_name = '{"ratio_up_right", "ratio_right", "ratio_down_right",
                         "ratio_down", "ratio_down_left", "ratio_left",
                         "ratio_up_left", "ratio_up"};
            beats_seen++;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: ratio beat for (%0d,%0d) arrived with none owed",
                             $realtime, got.row, got.col);
                return;
            end
            want = owed.pop_front();
            if (want.zero)
                zero_centres++;
            if (got.col !== want.col)
                flag("center_col", want.col, got.col);
            if (got.row !== want.row)
                flag("center_row", want.row, got.row);
            for (int k = 0; k < 8; k++)
                if (got.ratio[k] !== want.ratio[k])
                    flag(dir_name[k], want.ratio[k], got.ratio[k]);
            if (got.zero !== want.zero)
                flag("zero_center", want.zero, got.zero);
            if (got.last !== want.last)
                flag("frame_last", want.last, got.last);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  pixel;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        out_valid;
    logic        out_ready;
    logic [9:0]  center_col;
    logic [15:0] center_row;
    logic [15:0] ratio_up_right;
    logic [15:0] ratio_right;
    logic [15:0] ratio_down_right;
    logic [15:0] ratio_down;
    logic [15:0] ratio_down_left;
    logic [15:0] ratio_left;
    logic [15:0] ratio_up_left;
    logic [15:0] ratio_up;
    logic        zero_center;
    logic        frame_last;

    ratio_scoreboard sb;

    // Gap control. Gaps come in bursts, and the rate changes from phase to phase
    // so that some phases run back to back with no gap at all.
    bit gaps_on;
    int gap_odds;
    int random_pixels;

    neighbor_ratio_map dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pixel            (pixel),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .center_col       (center_col),
        .center_row       (center_row),
        .ratio_up_right   (ratio_up_right),
        .ratio_right      (ratio_right),
        .ratio_down_right (ratio_down_right),
        .ratio_down       (ratio_down),
        .ratio_down_left  (ratio_down_left),
        .ratio_left       (ratio_left),
        .ratio_up_left    (ratio_up_left),
        .ratio_up         (ratio_up),
        .zero_center      (zero_center),
        .frame_last       (frame_last)
    );

    always #10 clk = ~clk;

    // Receiver side. The ready line drops in random bursts while gaps are on.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (gaps_on && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Every beat taken at a clock edge is checked against the oldest owed beat.
    // Outputs are read at the edge, before the block updates them.
    always @(posedge clk)
    begin
        ratio_beat_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.col = center_col;
            got.row = center_row;
            got.ratio = '{ratio_up_right, ratio_right, ratio_down_right, ratio_down,
                          ratio_down_left, ratio_left, ratio_up_left, ratio_up};
            got.zero = zero_center;
            got.last = frame_last;
            sb.check_result(got);
        end
    end

    // Pixel values lean toward the edge cases: zero centres, full scale and one.
    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Sends one pixel beat. Valid stays high between back-to-back beats and is
    // only lowered when a burst of idle cycles is inserted.
    task automatic send_pixel(logic [7:0] px);
        if (gaps_on && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= px;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pixel(px);
    endtask

    task automatic send_random(int n);
        repeat (n)
            send_pixel(pick_pixel());
    endtask

    // Completes the frame in progress, so that the counters are back at the origin.
    task automatic finish_frame();
        while (sb.col_cnt != 0 || sb.row_cnt != 0)
            send_pixel(pick_pixel());
    endtask

    // The sender holds off until every owed beat has come back, then lets the
    // pipeline settle, since a pixel with no result may still be in flight.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(int idx, int unsigned val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx[0:0];
        cfg_data <= val[15:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        write_reg(CfgIdxWidth, w);
        write_reg(CfgIdxHeight, h);
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        logic [7:0]  pattern [9];
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        gaps_on = 1'b1;
        gap_odds = 4;
        random_pixels = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes: one full row of 156 and a few pixels of the next, then the
        // frame is cut to two rows of eight and closed.
        send_random(160);
        write_reg(CfgIdxHeight, 2);
        write_reg(CfgIdxWidth, 8);
        finish_frame();

        // A 3x3 frame with a zero centre next to a zero neighbour, full-scale
        // neighbours and a centre of one.
        pattern = '{8'd0, 8'd255, 8'd1, 8'd255, 8'd0, 8'd128, 8'd1, 8'd2, 8'd255};
        set_size(3, 3);
        foreach (pattern[i])
            send_pixel(pattern[i]);

        // Single pixel, single column, single row, then a 2x2 frame.
        set_size(0, 0);
        send_random(2);
        set_size(1, 5);
        send_random(5);
        set_size(5, 1);
        send_random(5);
        set_size(2, 2);
        send_random(4);

        // The height register at its top: a few rows, then a zero height ends the
        // frame from a row count past the new height.
        set_size(4, 65535);
        send_random(13);
        write_reg(CfgIdxHeight, 0);
        finish_frame();

        // A width past the line store length, then a narrower width that leaves the
        // column count past the row end, which closes the row at once.
        gap_odds = 20;
        set_size(2047, 1);
        send_random(6);
        write_reg(CfgIdxWidth, 3);
        send_random(1);

        // Random frame shapes with random content.
        while (random_pixels < 90)
        begin
            gap_odds = $urandom_range(0, 6);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 10);
            h = $urandom_range(1, 4);
            set_size(w, h);
            repeat ($urandom_range(1, 2))
            begin
                send_random(w * h);
                random_pixels += w * h;
            end
        end

        // The final frame runs without gaps on either side.
        gaps_on = 1'b0;
        set_size(8, 4);
        send_random(32);

        drain();
        $display("Pushed %0d pixels over %0d frames; %0d ratio beats checked, %0d with a zero centre.",
                 sb.pixels_seen, sb.frames_done, sb.beats_seen, sb.zero_centres);
        $display("Widths from 0 to 2047 and heights from 0 to 65535 were programmed.");
        if (sb.mismatches == 0 && sb.owed.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog for a block that hangs on either handshake.
    initial
    begin
        #50ms;
        $display("Timeout with %0d ratio beats still owed", sb.owed.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
